/* rtl/isp_pkg.sv */
// ----------------------------------------------------------------------------
// isp_pkg
// Shared types and constants of the independent set partition counter.
// ----------------------------------------------------------------------------
package isp_pkg;

   // fixed field widths
   localparam int VERTEX_W = 4;
   localparam int REG_W    = 4;
   localparam int RESULT_W = 16;
   localparam int TDATA_W  = 2 * VERTEX_W;

   // item kinds carried on tuser
   localparam logic KIND_PAIR    = 1'b0;
   localparam logic KIND_COMPUTE = 1'b1;

   // register indexes
   localparam logic CSR_VERTEX_COUNT = 1'b0;
   localparam logic CSR_GROUP_COUNT  = 1'b1;

   // register reset values
   localparam logic [REG_W-1:0] VERTEX_COUNT_RESET = 4'd10;
   localparam logic [REG_W-1:0] GROUP_COUNT_RESET  = 4'd1;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_MARK,
      S_SRC,
      S_LATCH,
      S_SUB,
      S_DRAIN,
      S_RES
   } isp_state_type;

   // commands to the conflict table
   typedef struct packed {
      logic                add;
      logic                clear;
      logic [VERTEX_W-1:0] vertex_a;
      logic [VERTEX_W-1:0] vertex_b;
   } conflict_cmd_type;

endpackage

/* rtl/independent_set_partition_counter.sv */
// ----------------------------------------------------------------------------
// independent_set_partition_counter
// Counts partitions of the vertices into a given number of conflict-free
// groups with a subset DP held in on-chip memories.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tuser = kind (pair or compute), tdata = vertex_a, vertex_b.
//   A pair item stores a symmetric conflict and gives no result. A
//   compute item gives one item on the rsp channel with the partition
//   count, then the conflict table is empty again.
//   csr port: index 0 = vertex_count, index 1 = group_count; write only
//   while the block is idle.
// A compute item on n vertices first sweeps all subsets, marking free
// subsets and clearing the DP rows; then for each covered mask i it does
// one memory read-modify-write per submask of the uncovered rest, all
// through the one read port of the DP row memory.
// One item is worked on at a time; req_tready is high only when idle.
// The result sits in an output register, so a stalled receiver does not
// block pair items, but a following compute item waits for it at its end.
// Reset empties the conflict table, sets vertex_count to 10 and
// group_count to 1, and drops any pending result.
// ----------------------------------------------------------------------------
module independent_set_partition_counter #(
   parameter int MAX_VERTICES = 10,
   parameter int COUNT_WIDTH  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [isp_pkg::TDATA_W-1:0]  req_tdata,   // vertex_a [3:0], vertex_b [7:4]
   input  logic                         req_tuser,   // kind [0]
   // result channel
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [isp_pkg::RESULT_W-1:0] rsp_tdata,   // partition_count [15:0]
   // configuration port
   input  logic                         csr_wen,
   input  logic                         csr_index,
   input  logic [isp_pkg::REG_W-1:0]    csr_wdata
);
   import isp_pkg::*;

   localparam int MW      = MAX_VERTICES;
   localparam int SUBSETS = 1 << MAX_VERTICES;
   localparam int COLS    = MAX_VERTICES + 1;
   localparam int COL_W   = $clog2(COLS);
   localparam logic [REG_W-1:0] MV_REG = REG_W'(MAX_VERTICES);

   typedef logic [COLS-1:0][COUNT_WIDTH-1:0] row_type;

   // control state
   isp_state_type            state_ff, state_in;
   logic [REG_W-1:0]         vertex_count_ff, group_count_ff;
   logic                     rsp_tvalid_ff;
   logic [RESULT_W-1:0]      rsp_data_ff;
   logic                     pend_valid_ff;

   // datapath registers
   logic [MW-1:0]            idx_ff, idx_in;
   logic [MW-1:0]            i_ff, i_in;
   logic [MW-1:0]            s_ff, s_in;
   logic [MW-1:0]            top_ff;
   row_type                  w_ff;
   logic [MW-1:0]            pend_addr_ff;
   logic                     pend_top_ff;

   // memories
   row_type                  ways_mem [SUBSETS];
   logic                     ok_mem [SUBSETS];
   row_type                  rd_row_ff;
   logic                     ok_rd_ff;

   // control strobes
   logic                     mark_en, src_rd, latch_en, sub_issue, drain_en, res_load;
   logic                     out_free;

   logic [REG_W-1:0]         n_eff;
   logic [MW-1:0]            full_mask, rem, top_val, s_next;
   logic                     free_ok;
   logic                     rd_en, wr_en;
   logic [MW-1:0]            rd_addr, wr_addr;
   row_type                  wr_row, init_row, new_row;
   logic [RESULT_W-1:0]      result_val;
   conflict_cmd_type         cmd;

   // effective vertex count and mask bounds
   assign n_eff = (vertex_count_ff > MV_REG) ? MV_REG : vertex_count_ff;

   always_comb begin
      for (int k = 0; k < MW; k++) begin
         full_mask[k] = (REG_W'(k) < n_eff);
      end
   end

   assign rem    = full_mask ^ i_ff;
   assign s_next = (s_ff - MW'(1)) & rem;

   // highest uncovered vertex
   always_comb begin
      top_val = '0;
      for (int k = 0; k < MW; k++) begin
         if (rem[k]) begin
            top_val    = '0;
            top_val[k] = 1'b1;
         end
      end
   end

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && (req_tuser == KIND_COMPUTE)) begin
               state_in = S_MARK;
            end
         end
         S_MARK: begin
            if (idx_ff == full_mask) begin
               state_in = S_SRC;
            end
         end
         S_SRC: begin
            state_in = (i_ff == full_mask) ? S_RES : S_LATCH;
         end
         S_LATCH: state_in = S_SUB;
         S_SUB: begin
            if (s_next == '0) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: state_in = S_SRC;
         S_RES: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      mark_en    = 1'b0;
      src_rd     = 1'b0;
      latch_en   = 1'b0;
      sub_issue  = 1'b0;
      drain_en   = 1'b0;
      res_load   = 1'b0;
      case (state_ff)
         S_IDLE:  req_tready = 1'b1;
         S_MARK:  mark_en    = 1'b1;
         S_SRC:   src_rd     = 1'b1;
         S_LATCH: latch_en   = 1'b1;
         S_SUB:   sub_issue  = 1'b1;
         S_DRAIN: drain_en   = 1'b1;
         S_RES:   res_load   = out_free;
         default: req_tready = 1'b0;
      endcase
   end

   // conflict table commands
   always_comb begin
      cmd.add      = req_tvalid && req_tready && (req_tuser == KIND_PAIR);
      cmd.clear    = res_load;
      cmd.vertex_a = req_tdata[VERTEX_W-1:0];
      cmd.vertex_b = req_tdata[TDATA_W-1:VERTEX_W];
   end

   isp_conflict_table #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_conflict (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .test_mask (idx_ff),
      .test_ok   (free_ok)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         vertex_count_ff <= VERTEX_COUNT_RESET;
         group_count_ff  <= GROUP_COUNT_RESET;
         rsp_tvalid_ff   <= 1'b0;
         pend_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= sub_issue;
         if (csr_wen && (csr_index == CSR_VERTEX_COUNT)) begin
            vertex_count_ff <= csr_wdata;
         end
         if (csr_wen && (csr_index == CSR_GROUP_COUNT)) begin
            group_count_ff <= csr_wdata;
         end
         if (res_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // counters
   always_comb begin
      idx_in = idx_ff;
      i_in   = i_ff;
      s_in   = s_ff;
      if (req_tready) begin
         idx_in = '0;
         i_in   = '0;
      end
      if (mark_en) begin
         idx_in = idx_ff + MW'(1);
      end
      if (drain_en) begin
         i_in = i_ff + MW'(1);
      end
      if (latch_en) begin
         s_in = rem;
      end
      if (sub_issue) begin
         s_in = s_next;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      i_ff         <= i_in;
      s_ff         <= s_in;
      pend_addr_ff <= i_ff | s_ff;
      pend_top_ff  <= ((s_ff & top_ff) != '0);
      if (latch_en) begin
         w_ff   <= rd_row_ff;
         top_ff <= top_val;
      end
      if (res_load) begin
         rsp_data_ff <= result_val;
      end
   end

   // initial row content of the sweep
   always_comb begin
      init_row = '0;
      if (idx_ff == '0) begin
         init_row[0] = COUNT_WIDTH'(1);
      end
   end

   // add the source row, shifted one group, into the target row
   always_comb begin
      new_row = rd_row_ff;
      for (int j = 1; j < COLS; j++) begin
         if (REG_W'(j) <= group_count_ff) begin
            new_row[j] = rd_row_ff[j] + w_ff[j-1];
         end
      end
   end

   // memory port selection
   assign rd_en   = src_rd || sub_issue;
   assign rd_addr = src_rd ? i_ff : (i_ff | s_ff);
   assign wr_en   = mark_en || (pend_valid_ff && pend_top_ff && ok_rd_ff);
   assign wr_addr = mark_en ? idx_ff : pend_addr_ff;
   assign wr_row  = mark_en ? init_row : new_row;

   // dp row memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ways_mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_row_ff <= ways_mem[rd_addr];
      end
   end

   // free subset memory
   always_ff @(posedge clock) begin
      if (mark_en) begin
         ok_mem[idx_ff] <= free_ok;
      end
      if (sub_issue) begin
         ok_rd_ff <= ok_mem[s_ff];
      end
   end

   // final count from the full-mask row
   always_comb begin
      if (group_count_ff > n_eff) begin
         result_val = '0;
      end else begin
         result_val = rd_row_ff[COL_W'(group_count_ff)][RESULT_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // a result appears only from the result state
   a_rsp_from_res: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == S_RES))
      else $error("result raised outside result state");

   // a pending write never hits the source row being expanded
   a_pend_not_source: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (pend_addr_ff != i_ff))
      else $error("dp write targets its own source row");

   // source read waits until the last write of the previous row has landed
   a_src_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRC) |-> !pend_valid_ff)
      else $error("source row read with a write still pending");

   // submask stays a nonzero subset of the uncovered vertices
   a_submask_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUB) |-> ((s_ff != '0) && ((s_ff & ~rem) == '0)))
      else $error("submask outside uncovered set");
`endif

endmodule

/* rtl/isp_conflict_table.sv */
// ----------------------------------------------------------------------------
// isp_conflict_table
// Symmetric conflict rows with pair insert, clear and a conflict-free test
// of one vertex subset per cycle.
// ----------------------------------------------------------------------------
module isp_conflict_table #(
   parameter int MAX_VERTICES = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  isp_pkg::conflict_cmd_type     cmd,
   input  logic [MAX_VERTICES-1:0]       test_mask,
   output logic                          test_ok
);
   import isp_pkg::*;

   localparam logic [VERTEX_W-1:0] MV_CODE = VERTEX_W'(MAX_VERTICES);

   logic [MAX_VERTICES-1:0] rows_ff [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] rows_in [MAX_VERTICES];
   logic                    pair_ok;

   // a pair counts only with both vertices in range and distinct
   assign pair_ok = cmd.add && (cmd.vertex_a < MV_CODE) && (cmd.vertex_b < MV_CODE) &&
                    (cmd.vertex_a != cmd.vertex_b);

   // row update: set both mirror bits, or clear everything
   always_comb begin
      for (int r = 0; r < MAX_VERTICES; r++) begin
         for (int c = 0; c < MAX_VERTICES; c++) begin
            rows_in[r][c] = rows_ff[r][c] |
               (pair_ok && (((cmd.vertex_a == VERTEX_W'(r)) && (cmd.vertex_b == VERTEX_W'(c))) ||
                            ((cmd.vertex_b == VERTEX_W'(r)) && (cmd.vertex_a == VERTEX_W'(c)))));
         end
         if (cmd.clear) begin
            rows_in[r] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < MAX_VERTICES; r++) begin
         if (reset) begin
            rows_ff[r] <= '0;
         end else begin
            rows_ff[r] <= rows_in[r];
         end
      end
   end

   // subset is free when no member conflicts with another member
   always_comb begin
      test_ok = 1'b1;
      for (int v = 0; v < MAX_VERTICES; v++) begin
         if (test_mask[v] && ((rows_ff[v] & test_mask) != '0)) begin
            test_ok = 1'b0;
         end
      end
   end

endmodule

/* tb/tb_independent_set_partition_counter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_independent_set_partition_counter
// Self-checking bench for the partition counter. Conflict pairs and compute
// items go in on the req stream; every compute item's count is predicted
// from a mirror of the conflict table and the two registers and compared
// with the rsp stream. The run walks through several register settings,
// directed corner cases, random pair/compute sequences and backpressure.
// ----------------------------------------------------------------------------
module tb_independent_set_partition_counter;
   import isp_pkg::*;

   localparam int VERTEX_SLOTS  = 10;
   localparam int SUBSET_SLOTS  = 1 << VERTEX_SLOTS;
   localparam int RANDOM_ITEMS  = 80;
   localparam int HOLD_CYCLES   = 500;
   localparam int SETTLE_CYCLES = 20;
   localparam int DRAIN_CYCLES  = 200;
   localparam int RUN_LIMIT     = 2000000;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct {
      logic                kind;
      logic [VERTEX_W-1:0] vertex_a;
      logic [VERTEX_W-1:0] vertex_b;
   } req_item_type;

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [TDATA_W-1:0]  req_tdata  = '0;
   logic                req_tuser  = KIND_PAIR;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RESULT_W-1:0] rsp_tdata;
   logic                csr_wen    = 1'b0;
   logic                csr_index  = CSR_VERTEX_COUNT;
   logic [REG_W-1:0]    csr_wdata  = '0;

   // bench state
   req_item_type        queued_requests[$];
   logic [RESULT_W-1:0] expected_counts[$];
   req_item_type        next_item;
   logic [RESULT_W-1:0] wanted_count;
   idle_mode_type       idle_mode      = IDLE_NONE;
   logic                hold_phase     = 1'b0;
   logic                hold_done      = 1'b0;
   int unsigned         hold_left      = 0;
   int unsigned         cycle_count    = 0;
   int                  error_count    = 0;
   int                  random_items   = 0;

   // mirror of the block's conflict table and registers
   logic [VERTEX_SLOTS-1:0] conflict_mirror [VERTEX_SLOTS];
   logic [REG_W-1:0]        vertex_limit;
   logic [REG_W-1:0]        group_target;
   logic [RESULT_W-1:0]     ways_mem [SUBSET_SLOTS][VERTEX_SLOTS+1];
   bit                      free_set [SUBSET_SLOTS];

   independent_set_partition_counter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // count of partitions of vertices 0..n-1 into t conflict-free groups
   function automatic logic [RESULT_W-1:0] predict_partition_count(input int n, input int t);
      int unsigned full, rest, top_v, sub, i, j, v;
      logic [RESULT_W-1:0] w;
      bit ok;
      full = (1 << n) - 1;
      for (i = 0; i <= full; i++) begin
         for (j = 0; j <= VERTEX_SLOTS; j++) ways_mem[i][j] = '0;
      end
      ways_mem[0][0] = RESULT_W'(1);
      if (t > n) return '0;
      // a subset is free when none of its members conflict with another member
      for (sub = 0; sub <= full; sub++) begin
         ok = 1'b1;
         for (v = 0; v < n; v++) begin
            if (sub[v] && ((conflict_mirror[v] & sub) != 0)) ok = 1'b0;
         end
         free_set[sub] = ok;
      end
      // each new group takes the highest vertex still uncovered
      for (i = 0; i < full; i++) begin
         rest  = full ^ i;
         top_v = 0;
         for (v = 0; v < n; v++) begin
            if (rest[v]) top_v = v;
         end
         for (j = 0; j < t; j++) begin
            w = ways_mem[i][j];
            if (w != 0) begin
               sub = rest;
               while (sub != 0) begin
                  if (sub[top_v] && free_set[sub]) ways_mem[i | sub][j+1] += w;
                  sub = (sub - 1) & rest;
               end
            end
         end
      end
      return ways_mem[full][t];
   endfunction

   // driver: one item on the bus at a time, random gaps per idle mode
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (queued_requests.size() != 0 &&
             !((idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 62) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 28))) begin
            next_item = queued_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_item.kind;
            req_tdata  <= {next_item.vertex_b, next_item.vertex_a};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off when a phase asks for it
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_phase && !hold_done && rsp_tvalid) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= !((idle_mode == IDLE_RECEIVER && $urandom_range(0, 99) < 62) ||
                         (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 28));
      end
   end

   // monitor: track registers and conflicts, predict on compute, check results
   always @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < VERTEX_SLOTS; r++) conflict_mirror[r] = '0;
         vertex_limit = VERTEX_COUNT_RESET;
         group_target = GROUP_COUNT_RESET;
      end else begin
         if (csr_wen) begin
            if (csr_index == CSR_VERTEX_COUNT) vertex_limit = csr_wdata;
            else group_target = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == KIND_PAIR) begin
               if (req_tdata[3:0] < VERTEX_SLOTS && req_tdata[7:4] < VERTEX_SLOTS &&
                   req_tdata[3:0] != req_tdata[7:4]) begin
                  conflict_mirror[req_tdata[3:0]][req_tdata[7:4]] = 1'b1;
                  conflict_mirror[req_tdata[7:4]][req_tdata[3:0]] = 1'b1;
               end
            end else begin
               expected_counts.insert(expected_counts.size(), predict_partition_count(
                  (vertex_limit > VERTEX_SLOTS) ? VERTEX_SLOTS : int'(vertex_limit),
                  int'(group_target)));
               for (int r = 0; r < VERTEX_SLOTS; r++) conflict_mirror[r] = '0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_counts.size() == 0) begin
               $error("partition_count: expected none, actual %0d", rsp_tdata);
               error_count++;
            end else begin
               wanted_count = expected_counts.pop_front();
               if (rsp_tdata !== wanted_count) begin
                  $error("partition_count: expected %0d, actual %0d", wanted_count, rsp_tdata);
                  error_count++;
               end
            end
         end
      end
   end

   task automatic push_pair(input int a, input int b);
      req_item_type it;
      it.kind     = KIND_PAIR;
      it.vertex_a = a[VERTEX_W-1:0];
      it.vertex_b = b[VERTEX_W-1:0];
      queued_requests.insert(queued_requests.size(), it);
   endtask

   // vertex fields carry noise on compute items
   task automatic push_compute();
      req_item_type it;
      it.kind     = KIND_COMPUTE;
      it.vertex_a = VERTEX_W'($urandom_range(0, 15));
      it.vertex_b = VERTEX_W'($urandom_range(0, 15));
      queued_requests.insert(queued_requests.size(), it);
   endtask

   // pair runs closed by a compute; a few runs carry their pairs into the next
   task automatic push_sequences(input int count, input int n, input int max_pairs);
      int s, p, pairs;
      for (s = 0; s < count; s++) begin
         pairs = $urandom_range(0, max_pairs);
         for (p = 0; p < pairs; p++) begin
            if ($urandom_range(0, 9) < 8) push_pair($urandom_range(0, n-1), $urandom_range(0, n-1));
            else push_pair($urandom_range(0, 15), $urandom_range(0, 15));
         end
         random_items += pairs;
         if ($urandom_range(0, 9) < 9) begin
            push_compute();
            random_items++;
         end
      end
   endtask

   // wait until every item went in and every count came out
   task automatic wait_drained();
      do @(negedge clock);
      while (queued_requests.size() != 0 || req_tvalid || expected_counts.size() != 0);
   endtask

   // registers only change once the block has gone idle
   task automatic configure(input int vc, input int gc);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= CSR_VERTEX_COUNT;
      csr_wdata <= vc[REG_W-1:0];
      @(posedge clock);
      csr_index <= CSR_GROUP_COUNT;
      csr_wdata <= gc[REG_W-1:0];
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   task automatic start_phase(input idle_mode_type mode, input logic hold);
      @(negedge clock);
      idle_mode  = mode;
      hold_phase = hold;
   endtask

   // stimulus
   initial begin
      int phase_no;
      int vc;
      int gc;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset registers: ten vertices, one group; out-of-range and self pairs do nothing
      start_phase(IDLE_NONE, 1'b0);
      push_pair(15, 15);
      push_pair(10, 3);
      push_pair(3, 3);
      push_compute();

      // path on four vertices, pairs beyond the vertex count stored but unused
      configure(4, 2);
      push_pair(0, 1);
      push_pair(2, 1);
      push_pair(3, 2);
      push_pair(9, 0);
      push_pair(8, 7);
      push_pair(7, 8);
      push_compute();
      // table is empty again after a compute
      push_pair(0, 2);
      push_compute();

      // empty vertex set with zero groups, then with too many groups
      configure(0, 0);
      push_compute();
      configure(0, 15);
      push_compute();
      // zero groups with one vertex
      configure(1, 0);
      push_compute();
      // more groups than vertices
      configure(3, 10);
      push_pair(0, 1);
      push_compute();
      // vertex count above the maximum saturates, all singletons
      configure(15, 10);
      push_pair(12, 5);
      push_compute();

      // random phases
      phase_no = 0;
      while (random_items < RANDOM_ITEMS) begin
         case (phase_no)
            0: begin
               // long receiver hold-off while computes keep coming
               configure(3, $urandom_range(1, 3));
               start_phase(IDLE_NONE, 1'b1);
               push_sequences(6, 3, 3);
            end
            1: begin
               // sender pauses midway until every count is back
               configure(5, $urandom_range(1, 5));
               start_phase(IDLE_SENDER, 1'b0);
               push_sequences(3, 5, 5);
               wait_drained();
               push_sequences(3, 5, 5);
            end
            2: begin
               // one dense run on the full vertex set
               configure(10, $urandom_range(3, 6));
               start_phase(IDLE_BOTH, 1'b0);
               push_sequences(1, 10, 10);
            end
            default: begin
               vc = $urandom_range(2, 6);
               gc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, vc);
               configure(vc, gc);
               start_phase(idle_mode_type'(phase_no % 4), 1'b0);
               push_sequences(4, vc, 5);
            end
         endcase
         wait_drained();
         phase_no++;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // runaway guard
   initial begin
      wait (cycle_count >= RUN_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

endmodule
